>>> rtl/core/eacu_pkg.sv
// eacu_pkg: shared constants and types for the camera update block
// no dependencies
package eacu_pkg;
    localparam int CordicSteps = 14;
    localparam int NumIter = (CordicSteps < 20) ? CordicSteps : 20;
    localparam int PositionWidth = 32;
    localparam int IterW = 5;
    localparam int YawWrapSteps = 10;

    localparam logic signed [17:0] YawHalfTurn = 18'sd46080;
    localparam logic signed [17:0] YawTurn = 18'sd92160;
    localparam logic signed [17:0] QuarterTurn = 18'sd23040;
    // half turn plus 256 turns, keeps the yaw sum positive
    localparam logic signed [26:0] YawBias = 27'sd23639040;
    localparam logic signed [34:0] CordicStart = 35'sd652032874;
    localparam logic signed [15:0] Unit14 = 16'sd16384;

    localparam logic [1:0] REG_SENS = 2'd0;
    localparam logic [1:0] REG_SPEED = 2'd1;
    localparam logic [1:0] REG_PLIM = 2'd2;

    localparam logic CMD_MOUSE = 1'b0;
    localparam logic CMD_MOVE = 1'b1;

    typedef logic signed [PositionWidth-1:0] pos_t;

    function automatic logic signed [23:0] atan_lut(input logic [IterW-1:0] i);
        logic signed [23:0] r;
        unique case (i)
            5'd0: r = 24'sd2949120;  5'd1: r = 24'sd1740967;
            5'd2: r = 24'sd919879;   5'd3: r = 24'sd466945;
            5'd4: r = 24'sd234379;   5'd5: r = 24'sd117304;
            5'd6: r = 24'sd58666;    5'd7: r = 24'sd29335;
            5'd8: r = 24'sd14668;    5'd9: r = 24'sd7334;
            5'd10: r = 24'sd3667;    5'd11: r = 24'sd1833;
            5'd12: r = 24'sd917;     5'd13: r = 24'sd458;
            5'd14: r = 24'sd229;     5'd15: r = 24'sd115;
            5'd16: r = 24'sd57;      5'd17: r = 24'sd29;
            5'd18: r = 24'sd14;      5'd19: r = 24'sd7;
            default: r = 24'sd0;
        endcase
        return r;
    endfunction

    function automatic logic signed [15:0] clamp14(input logic signed [35:0] v);
        logic signed [15:0] r;
        if (v > 36'sd16384) r = Unit14;
        else if (v < -36'sd16384) r = -Unit14;
        else r = v[15:0];
        return r;
    endfunction
endpackage

>>> rtl/core/euler_angle_camera_update.sv
// euler_angle_camera_update: fps camera, mouse turn and keyboard move
// depends on eacu_pkg
//
// channel | dir | fields
// s_      | in  | tuser command; tdata cursor_x, cursor_y, key_mask, delta_time
// m_      | out | tdata pos_x, pos_y, pos_z, front_x, front_y, front_z
// cfg_    | in  | wr_en, index, data
//
// a mouse item runs the yaw wrap and two cordic passes (yaw, then pitch), a
// movement item one yaw pass and a step for each pressed key; one shared
// cordic shift/add unit and one 32x32 multiplier are stepped by the sequencer.
// s_axis_tready is low while an item is in work or its result waits.
// reset is synchronous, active low.
module euler_angle_camera_update import eacu_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [55:0]  s_axis_tdata,  // cursor_x, cursor_y, key_mask, delta_time
    input  logic         s_axis_tuser,  // command
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [143:0] m_axis_tdata,  // pos_x, pos_y, pos_z, front_x, front_y, front_z
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);
    localparam logic [4:0] S_IDLE = 5'd0, S_MD = 5'd1, S_MYAW = 5'd2, S_MPIT = 5'd3,
        S_CPRE = 5'd4, S_CIT = 5'd5, S_CPOST = 5'd6, S_FX = 5'd7, S_FZ = 5'd8,
        S_FDONE = 5'd9, S_SPD = 5'd10, S_RGT = 5'd11, S_KEY = 5'd12, S_MUL = 5'd13,
        S_ADD = 5'd14, S_OUT = 5'd15, S_MD2 = 5'd16, S_MYAW2 = 5'd17;

    logic [15:0] sens_reg, speed_reg;
    logic [14:0] plim_reg;
    logic signed [16:0] yaw_reg;
    logic signed [15:0] pitch_reg, lcx_reg, lcy_reg;
    logic first_reg;
    pos_t pos_reg [3];
    logic signed [15:0] front_reg [3];
    logic signed [15:0] right_reg [3];
    logic [4:0] st_reg, ret_reg;
    logic [3:0] keys_reg;
    logic [15:0] dt_reg;
    logic signed [16:0] dx_reg, dy_reg;
    logic signed [35:0] x_reg, y_reg;
    logic signed [25:0] z_reg;
    logic neg_reg;
    logic [IterW-1:0] it_reg;
    logic pass_reg;
    logic signed [35:0] cyaw_reg, syaw_reg;
    logic [31:0] spd_reg;
    logic signed [63:0] prod_reg;
    logic [1:0] comp_reg, key_reg;
    logic [25:0] yred_reg;
    logic [143:0] out_reg;
    logic ov_reg;

    // shared 32x32 multiplier
    logic signed [32:0] ma, mb;
    logic signed [65:0] mp;
    assign mp = ma * mb;

    logic signed [17:0] dlim;
    assign dlim = (plim_reg > 15'd23040) ? QuarterTurn : {3'b0, plim_reg};

    logic signed [16:0] ang_sel;
    logic signed [17:0] ang_adj;
    assign ang_sel = pass_reg ? {pitch_reg[15], pitch_reg} : yaw_reg;
    assign ang_adj = (ang_sel > QuarterTurn) ? ang_sel - YawHalfTurn :
                     (ang_sel < -QuarterTurn) ? ang_sel + YawHalfTurn : 18'(ang_sel);

    logic signed [35:0] xs, ys;
    assign xs = x_reg >>> it_reg;
    assign ys = y_reg >>> it_reg;

    logic signed [15:0] dir_c;
    assign dir_c = key_reg[1] ? right_reg[comp_reg] : front_reg[comp_reg];
    logic signed [63:0] step;
    assign step = (prod_reg + 64'sd536870912) >>> 30;

    logic signed [33:0] d_r;
    assign d_r = 34'((prod_reg + 64'sd128) >>> 8);

    // yaw wrap by compare and subtract of shifted turns
    logic [25:0] ysum, ysh, yrem;
    logic signed [17:0] yfin;
    assign ysum = 26'(36'(yaw_reg) + 36'(d_r) + 36'(YawBias));
    assign ysh = 26'(YawTurn) << it_reg;
    assign yrem = (yred_reg >= ysh) ? yred_reg - ysh : yred_reg;
    assign yfin = $signed({1'b0, yrem[16:0]}) - YawHalfTurn;

    logic signed [34:0] pv;
    assign pv = 35'(pitch_reg) + 35'(d_r);

    always_comb begin
        ma = '0; mb = '0;
        unique case (st_reg)
            S_MD: begin ma = 33'(dx_reg); mb = {17'b0, sens_reg}; end
            S_MD2: begin ma = 33'(dy_reg); mb = {17'b0, sens_reg}; end
            S_SPD: begin ma = {17'b0, speed_reg}; mb = {17'b0, dt_reg}; end
            S_MUL: begin ma = 33'(dir_c); mb = {1'b0, spd_reg}; end
            S_FX: begin ma = 33'(cyaw_reg); mb = 33'(x_reg); end
            S_FZ: begin ma = 33'(syaw_reg); mb = 33'(x_reg); end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sens_reg <= 16'd6554; speed_reg <= 16'd2560; plim_reg <= 15'd22784;
            yaw_reg <= -17'sd23040; pitch_reg <= '0;
            lcx_reg <= 16'sd400; lcy_reg <= 16'sd300; first_reg <= 1'b1;
            pos_reg[0] <= '0; pos_reg[1] <= pos_t'(1280); pos_reg[2] <= pos_t'(5120);
            front_reg[0] <= '0; front_reg[1] <= '0; front_reg[2] <= -Unit14;
            st_reg <= S_IDLE; ov_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_SENS: sens_reg <= cfg_data;
                    REG_SPEED: speed_reg <= cfg_data;
                    REG_PLIM: plim_reg <= cfg_data[14:0];
                    default: ;
                endcase
            end
            if (ov_reg && m_axis_tready) ov_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE: if (s_axis_tvalid && !ov_reg) begin
                    keys_reg <= s_axis_tdata[35:32];
                    dt_reg <= s_axis_tdata[51:36];
                    pass_reg <= 1'b0;
                    if (s_axis_tuser == CMD_MOVE) begin
                        ret_reg <= S_SPD; st_reg <= S_CPRE;
                    end else begin
                        if (first_reg) begin
                            dx_reg <= '0; dy_reg <= '0;
                        end else begin
                            dx_reg <= 17'($signed(s_axis_tdata[15:0])) - 17'(lcx_reg);
                            dy_reg <= 17'(lcy_reg) - 17'($signed(s_axis_tdata[31:16]));
                        end
                        first_reg <= 1'b0;
                        lcx_reg <= s_axis_tdata[15:0];
                        lcy_reg <= s_axis_tdata[31:16];
                        st_reg <= S_MD;
                    end
                end
                S_MD: begin prod_reg <= 64'(mp); st_reg <= S_MYAW; end
                S_MYAW: begin
                    yred_reg <= ysum;
                    it_reg <= IterW'(YawWrapSteps - 1);
                    st_reg <= S_MYAW2;
                end
                S_MYAW2: begin
                    yred_reg <= yrem;
                    if (it_reg == '0) begin
                        yaw_reg <= yfin[16:0]; st_reg <= S_MD2;
                    end else it_reg <= it_reg - 1'b1;
                end
                S_MD2: begin prod_reg <= 64'(mp); st_reg <= S_MPIT; end
                S_MPIT: begin
                    if (pv > 35'(dlim)) pitch_reg <= 16'(dlim);
                    else if (pv < -35'(dlim)) pitch_reg <= 16'(-dlim);
                    else pitch_reg <= 16'(pv);
                    ret_reg <= S_FX; st_reg <= S_CPRE;
                end
                S_CPRE: begin
                    neg_reg <= (ang_sel > QuarterTurn) || (ang_sel < -QuarterTurn);
                    z_reg <= 26'(ang_adj) <<< 8;
                    x_reg <= 36'(CordicStart); y_reg <= '0; it_reg <= '0;
                    st_reg <= S_CIT;
                end
                S_CIT: begin
                    if (z_reg >= 0) begin
                        x_reg <= x_reg - ys; y_reg <= y_reg + xs;
                        z_reg <= z_reg - 26'(atan_lut(it_reg));
                    end else begin
                        x_reg <= x_reg + ys; y_reg <= y_reg - xs;
                        z_reg <= z_reg + 26'(atan_lut(it_reg));
                    end
                    it_reg <= it_reg + 1'b1;
                    if (it_reg == IterW'(NumIter - 1)) st_reg <= S_CPOST;
                end
                S_CPOST: begin
                    if (neg_reg) begin x_reg <= -x_reg; y_reg <= -y_reg; end
                    if (!pass_reg) begin
                        cyaw_reg <= neg_reg ? -x_reg : x_reg;
                        syaw_reg <= neg_reg ? -y_reg : y_reg;
                    end
                    if (ret_reg == S_FX && !pass_reg) begin
                        pass_reg <= 1'b1; st_reg <= S_CPRE;
                    end else st_reg <= ret_reg;
                end
                S_FX: begin
                    // x_reg/y_reg hold cos/sin of pitch
                    front_reg[1] <= clamp14(36'((y_reg + 36'sd32768) >>> 16));
                    prod_reg <= 64'(mp);
                    st_reg <= S_FZ;
                end
                S_FZ: begin
                    front_reg[0] <= clamp14(36'((prod_reg + 64'sd35184372088832) >>> 46));
                    prod_reg <= 64'(mp);
                    st_reg <= S_FDONE;
                end
                S_FDONE: begin
                    front_reg[2] <= clamp14(36'((prod_reg + 64'sd35184372088832) >>> 46));
                    st_reg <= S_OUT;
                end
                S_SPD: begin
                    spd_reg <= mp[31:0];
                    st_reg <= S_RGT;
                end
                S_RGT: begin
                    right_reg[0] <= clamp14(36'((-syaw_reg + 36'sd32768) >>> 16));
                    right_reg[1] <= '0;
                    right_reg[2] <= clamp14(36'((cyaw_reg + 36'sd32768) >>> 16));
                    key_reg <= '0; comp_reg <= '0;
                    st_reg <= S_KEY;
                end
                S_KEY: begin
                    if (keys_reg[key_reg]) st_reg <= S_MUL;
                    else if (key_reg == 2'd3) st_reg <= S_OUT;
                    else key_reg <= key_reg + 1'b1;
                end
                S_MUL: begin prod_reg <= 64'(mp); st_reg <= S_ADD; end
                S_ADD: begin
                    logic signed [PositionWidth+1:0] sum;
                    sum = (PositionWidth+2)'(pos_reg[comp_reg]) +
                          ((key_reg == 2'd0 || key_reg == 2'd3) ?
                          (PositionWidth+2)'(step) : -(PositionWidth+2)'(step));
                    if (sum > $signed((PositionWidth+2)'({1'b0, {(PositionWidth-1){1'b1}}})))
                        pos_reg[comp_reg] <= {1'b0, {(PositionWidth-1){1'b1}}};
                    else if (sum <
                             -$signed((PositionWidth+2)'({1'b1, {(PositionWidth-1){1'b0}}})))
                        pos_reg[comp_reg] <= {1'b1, {(PositionWidth-1){1'b0}}};
                    else pos_reg[comp_reg] <= sum[PositionWidth-1:0];
                    if (comp_reg == 2'd2) begin
                        comp_reg <= '0;
                        if (key_reg == 2'd3) st_reg <= S_OUT;
                        else begin key_reg <= key_reg + 1'b1; st_reg <= S_KEY; end
                    end else begin
                        comp_reg <= comp_reg + 1'b1; st_reg <= S_MUL;
                    end
                end
                S_OUT: begin
                    out_reg <= {front_reg[2], front_reg[1], front_reg[0],
                                32'(pos_reg[2]), 32'(pos_reg[1]), 32'(pos_reg[0])};
                    ov_reg <= 1'b1;
                    st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (st_reg == S_IDLE) && !ov_reg;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata = out_reg;
endmodule

>>> rtl/core/eacu_checker.sv
// eacu_port_checker: port-level checks for the camera update block
// bound into euler_angle_camera_update; uses no package
module eacu_port_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [143:0] m_axis_tdata
);
    // a new item is only taken with no result pending
    a_no_accept_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |-> !m_axis_tvalid) else $error("accept while busy");
    // an accepted item blocks input next cycle
    a_busy_after: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("ready after accept");
    // held result keeps its data
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
    a_front_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> ($signed(m_axis_tdata[111:96]) <= 16'sd16384) &&
        ($signed(m_axis_tdata[111:96]) >= -16'sd16384)) else $error("front out of range");
endmodule

bind euler_angle_camera_update eacu_port_checker u_eacu_port_checker (
    .aclk(aclk), .aresetn(aresetn), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
